// File: src/bbpg_pkg.sv
// Package for the buzzer beep pattern generator.
// Holds command codes, field widths, register indexes and the state struct.
// No dependencies.
package bbpg_pkg;

  localparam int unsigned AmountW    = 16;
  localparam int unsigned DividerW   = 16;
  localparam int unsigned PhaseW     = 4;
  localparam int unsigned PhasesW    = 8;
  localparam int unsigned CountW     = 7;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [DividerW-1:0] DividerReset = 16'd100;
  localparam logic [PhaseW-1:0]   PhaseReset   = 4'd1;
  localparam logic [CountW-1:0]   CountMax     = 7'd127;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_BEEP   = 2'd1,
    CMD_SERIES = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_TICK_DIVIDER = 2'd0,
    REG_PHASE_TICKS  = 2'd1,
    REG_SPARE_2      = 2'd2,
    REG_SPARE_3      = 2'd3
  } reg_e;

  typedef struct packed {
    logic [DividerW-1:0] prescale_count;
    logic [PhaseW-1:0]   phase_count;
    logic [PhasesW-1:0]  phases_left;
    logic [AmountW-1:0]  long_left;
    logic                buzzer_on;
  } state_t;

  typedef struct packed {
    logic [DividerW-1:0] tick_divider;
    logic [PhaseW-1:0]   phase_ticks;
  } cfg_t;

endpackage

// File: src/bbpg_step.sv
// Next-state logic of the buzzer beep pattern generator for one command.
// Depends on bbpg_pkg.
module bbpg_step (
  input  bbpg_pkg::state_t              state_i,
  input  bbpg_pkg::cfg_t                cfg_i,
  input  logic [1:0]                    command_i,
  input  logic [bbpg_pkg::AmountW-1:0]  amount_i,
  output bbpg_pkg::state_t              state_o
);
  import bbpg_pkg::*;

  logic [CountW-1:0]  count;
  logic [PhasesW-1:0] phases_dec;
  logic [PhasesW-1:0] series_load;

  assign count       = (amount_i > AmountW'(CountMax)) ? CountMax : amount_i[CountW-1:0];
  assign series_load = {count, 1'b0} - PhasesW'(1);
  assign phases_dec  = state_i.phases_left - PhasesW'(1);

  always_comb begin
    state_o = state_i;
    case (cmd_e'(command_i))
      CMD_TICK: begin
        if (state_i.phases_left == '0 && state_i.long_left == '0) begin
          state_o.buzzer_on = 1'b0;
        end else if (state_i.prescale_count == cfg_i.tick_divider) begin
          state_o.prescale_count = '0;
          if (state_i.phases_left != '0) begin
            if (state_i.phase_count >= cfg_i.phase_ticks) begin
              state_o.phase_count = '0;
              state_o.phases_left = phases_dec;
              state_o.buzzer_on   = ~state_i.phases_left[0];
              if (phases_dec == '0) begin
                state_o.buzzer_on = 1'b0;
              end
            end else begin
              state_o.phase_count = state_i.phase_count + PhaseW'(1);
            end
          end else begin
            state_o.long_left = state_i.long_left - AmountW'(1);
          end
          if (state_o.phases_left == '0 && state_o.long_left == '0) begin
            state_o.buzzer_on = 1'b0;
          end
        end else begin
          state_o.prescale_count = state_i.prescale_count + DividerW'(1);
        end
      end
      CMD_BEEP: begin
        state_o.buzzer_on = 1'b1;
        state_o.long_left = amount_i;
      end
      CMD_SERIES: begin
        if (count == '0) begin
          state_o.phases_left = '0;
        end else begin
          if (state_i.phases_left == '0) begin
            state_o.buzzer_on = 1'b1;
          end
          state_o.phases_left = series_load;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// File: src/buzzer_beep_pattern_generator.sv
// Top level of the buzzer beep pattern generator: stream ports, input and
// result registers, configuration registers. Depends on bbpg_pkg and bbpg_step.
//
// Each command produces exactly one result, the buzzer level and the series
// flag after that command. The block takes one transaction per clock cycle
// while results are taken: a command is registered on acceptance, one pass
// of next-state logic updates the state and the result is registered, so a
// command moves from the input register into the result register; the input
// stalls only when both registers are full and the result is not taken.
// Configuration writes are always accepted and take effect at once.
module buzzer_beep_pattern_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [15:0] amount
  input  logic [1:0]                       s_axis_tuser,  // [1:0] command
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [0] buzzer_level, [1] series_active
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bbpg_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [bbpg_pkg::CfgDataW-1:0]    cfg_data_i
);
  import bbpg_pkg::*;

  cfg_t               cfg_q;
  state_t             state_q, state_d;
  logic               in_valid_q;
  logic [1:0]         in_cmd_q;
  logic [AmountW-1:0] in_amount_q;
  logic               out_valid_q;
  logic [1:0]         out_bits_q;
  logic               advance;

  assign advance       = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ~in_valid_q | advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_bits_q};

  bbpg_step u_step (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .command_i (in_cmd_q),
    .amount_i  (in_amount_q),
    .state_o   (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_divider <= DividerReset;
      cfg_q.phase_ticks  <= PhaseReset;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_TICK_DIVIDER: cfg_q.tick_divider <= cfg_data_i[DividerW-1:0];
        REG_PHASE_TICKS:  cfg_q.phase_ticks  <= cfg_data_i[PhaseW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q    <= s_axis_tuser;
      in_amount_q <= s_axis_tdata;
    end
    if (advance && in_valid_q) begin
      out_bits_q <= {(state_d.phases_left != '0), state_d.buzzer_on};
    end
  end

endmodule

// File: dv/tb.sv
// Self-checking testbench for buzzer_beep_pattern_generator.
// It drives command streams and register writes, predicts each result and compares them.
// Depends on bbpg_pkg and the buzzer_beep_pattern_generator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbpg_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  class buzzer_scoreboard;
    logic [DividerW-1:0] divider;
    logic [PhaseW-1:0]   phase_len;
    logic [DividerW-1:0] prescale;
    logic [PhaseW-1:0]   phase_cnt;
    logic [PhasesW-1:0]  phases;
    logic [AmountW-1:0]  beep_left;
    logic                buzz;
    logic [1:0]          levels_due[$];
    int                  mismatches;

    function new();
      divider    = DividerReset;
      phase_len  = PhaseReset;
      prescale   = '0;
      phase_cnt  = '0;
      phases     = '0;
      beep_left  = '0;
      buzz       = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (reg_e'(idx))
        REG_TICK_DIVIDER: divider = data;
        REG_PHASE_TICKS:  phase_len = data[PhaseW-1:0];
        default: ;
      endcase
    endfunction

    function void take_command(logic [1:0] cmd, logic [AmountW-1:0] amt);
      logic [CountW-1:0] count;
      case (cmd_e'(cmd))
        CMD_TICK: begin
          if (phases == 0 && beep_left == 0) begin
            buzz = 1'b0;
          end else if (prescale == divider) begin
            prescale = '0;
            if (phases != 0) begin
              if (phase_cnt >= phase_len) begin
                phase_cnt = '0;
                buzz = ~phases[0];
                phases = phases - 1'b1;
                if (phases == 0) buzz = 1'b0;
              end else begin
                phase_cnt = phase_cnt + 1'b1;
              end
            end else if (beep_left != 0) begin
              beep_left = beep_left - 1'b1;
            end
            if (phases == 0 && beep_left == 0) buzz = 1'b0;
          end else begin
            prescale = prescale + 1'b1;
          end
        end
        CMD_BEEP: begin
          buzz = 1'b1;
          beep_left = amt;
        end
        CMD_SERIES: begin
          count = (amt > CountMax) ? CountMax : amt[CountW-1:0];
          if (count == 0) begin
            phases = '0;
          end else begin
            if (phases == 0) buzz = 1'b1;
            phases = {count, 1'b0} - 1'b1;
          end
        end
        default: ;
      endcase
      levels_due.push_back({phases != 0, buzz});
    endfunction

    function void check_levels(logic [7:0] data);
      logic [1:0] want;
      if (levels_due.size() == 0) begin
        mismatches++;
        $error("result 0x%02h arrived with no command outstanding", data);
        return;
      end
      want = levels_due.pop_front();
      if (data[0] !== want[0]) begin
        mismatches++;
        $error("buzzer_level: expected %0d, actual %0d", want[0], data[0]);
      end
      if (data[1] !== want[1]) begin
        mismatches++;
        $error("series_active: expected %0d, actual %0d", want[1], data[1]);
      end
      if (data[7:2] !== 6'd0) begin
        mismatches++;
        $error("padding: expected 0, actual %0d", data[7:2]);
      end
    endfunction

    function int pending();
      return levels_due.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  buzzer_scoreboard sb = new();
  int unsigned      cycle_count = 0;
  bit               tx_steady = 1'b0;
  bit               rx_steady = 1'b0;

  buzzer_beep_pattern_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("buzzer_beep_pattern_generator test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_levels(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.take_command(s_axis_tuser, s_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken == 150 || taken == 600) begin
        stall = 60;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 6);
      end
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  task automatic put_reg(reg_e idx, logic [CfgDataW-1:0] data, bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [DividerW-1:0] div, logic [PhaseW-1:0] ticks,
                            bit touch_spare);
    put_reg(REG_TICK_DIVIDER, div, 1'b0);
    put_reg(REG_PHASE_TICKS, CfgDataW'(ticks), !touch_spare);
    if (touch_spare) begin
      put_reg(reg_e'(CfgIndexW'($urandom_range(2, 3))), 16'($urandom), 1'b1);
    end
  endtask

  task automatic send_cmd(cmd_e cmd, logic [AmountW-1:0] amt);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= amt;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_random();
    int pick;
    logic [AmountW-1:0] amt;
    pick = $urandom_range(0, 99);
    amt  = 16'($urandom);
    if (pick < 72) begin
      send_cmd(CMD_TICK, amt);
    end else if (pick < 84) begin
      send_cmd(CMD_BEEP, ($urandom_range(0, 7) == 0) ? amt : 16'($urandom_range(0, 12)));
    end else if (pick < 95) begin
      send_cmd(CMD_SERIES, ($urandom_range(0, 5) == 0) ? amt : 16'($urandom_range(0, 4)));
    end else begin
      send_cmd(CMD_NONE, amt);
    end
  endtask

  initial begin : stimulus
    logic [DividerW-1:0] div;
    logic [PhaseW-1:0]   ticks;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(CMD_TICK, 16'hFFFF);
    send_cmd(CMD_NONE, 16'hFFFF);
    send_cmd(CMD_BEEP, 16'd0);
    send_cmd(CMD_TICK, 16'd0);
    drain();

    set_config(16'd1, 4'd0, 1'b0);
    send_cmd(CMD_SERIES, 16'd0);
    send_cmd(CMD_SERIES, 16'd1);
    send_cmd(CMD_TICK, 16'hAAAA);
    send_cmd(CMD_TICK, 16'h5555);
    send_cmd(CMD_TICK, 16'd0);
    send_cmd(CMD_BEEP, 16'hFFFF);
    send_cmd(CMD_SERIES, 16'hFFFF);
    send_cmd(CMD_SERIES, 16'd128);
    send_cmd(CMD_TICK, 16'd0);
    send_cmd(CMD_TICK, 16'd0);
    send_cmd(CMD_SERIES, 16'd0);
    send_cmd(CMD_TICK, 16'd0);
    drain();

    set_config(16'd200, 4'd1, 1'b0);
    send_cmd(CMD_BEEP, 16'd3);
    repeat (5) send_cmd(CMD_TICK, 16'($urandom));
    drain();
    set_config(16'd2, 4'd1, 1'b0);
    repeat (3) send_cmd(CMD_TICK, 16'($urandom));
    drain();

    for (int p = 0; p < 9; p++) begin
      div   = (p == 3) ? 16'hFFFF : (p == 6) ? DividerReset : 16'($urandom_range(1, 4));
      ticks = (p == 1) ? 4'd15 : (p == 2) ? 4'd0 : 4'($urandom_range(0, 5));
      set_config(div, ticks, p == 4);
      repeat (120) send_random();
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("buzzer_beep_pattern_generator test passed");
    end else begin
      $display("buzzer_beep_pattern_generator test failed");
    end
    $finish;
  end

endmodule
